### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the window average deadband block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// When the condition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, cond, cons)
`endif
`endif

### rtl/awd_pkg.sv
// Shared types and constants for the window average deadband block.
package awd_pkg;

  localparam int CH_W       = 4;
  localparam int SAMPLE_W   = 12;
  localparam int CIU_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int SAMPLE_MAX = 4095;
  localparam int SUM_SLACK  = 100;

  localparam int CHANNELS_DEFAULT = 16;
  localparam int WINDOW_DEFAULT   = 8;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd16;
  localparam logic [CIU_W-1:0]    CIU_RESET       = 5'd16;

  // Result queue behind the pipeline.
  localparam int OUT_DEPTH = 8;
  localparam int OQ_AW     = $clog2(OUT_DEPTH);
  localparam int OQ_CW     = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE      = 2'd0,
    REG_DEADBAND_ENABLE    = 2'd1,
    REG_DEADBAND_THRESHOLD = 2'd2,
    REG_CHANNELS_IN_USE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic             empty;
    logic [OQ_CW-1:0] count;
  } outq_status_t;

endpackage

### rtl/awd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module awd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/awd_outq.sv
// Result queue that decouples the filter pipeline from the output handshake.
`include "assert_macros.svh"
module awd_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  awd_pkg::result_t       push_data,
  input  logic                   pop,
  output awd_pkg::result_t       head,
  output awd_pkg::outq_status_t  status
);

  awd_pkg::result_t entries [awd_pkg::OUT_DEPTH];

  logic [awd_pkg::OQ_AW-1:0] wr_ptr;
  logic [awd_pkg::OQ_AW-1:0] rd_ptr;
  logic [awd_pkg::OQ_CW-1:0] count;
  logic [awd_pkg::OQ_CW-1:0] count_next;

  localparam logic [awd_pkg::OQ_AW-1:0] PTR_LAST = awd_pkg::OQ_AW'(awd_pkg::OUT_DEPTH - 1);
  localparam logic [awd_pkg::OQ_CW-1:0] COUNT_FULL = awd_pkg::OQ_CW'(awd_pkg::OUT_DEPTH);

  assign count_next = count + awd_pkg::OQ_CW'(push) - awd_pkg::OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && count == COUNT_FULL))

endmodule

### rtl/adc_window_average_deadband_core.sv
// Top level: per-channel sliding window average with deadband hold, fed by two RAMs.
// Accepted words pass the pipeline stages and then the result queue to the output.
// Throughput: one word per cycle on any channel mix; the four-stage RAM pipeline
// forwards channel state between stages, and input is held back only when the
// eight-entry result queue together with the words in flight is full.
// Reset clears valid flags, config and channel valid bits at once; no sweep runs.
`include "assert_macros.svh"
module adc_window_average_deadband_core #(
  parameter int CHANNELS = awd_pkg::CHANNELS_DEFAULT,
  parameter int WINDOW   = awd_pkg::WINDOW_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [awd_pkg::CH_W-1:0]         channel,
  input  logic [awd_pkg::SAMPLE_W-1:0]     sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [awd_pkg::CH_W-1:0]         channel_out,
  output logic [awd_pkg::SAMPLE_W-1:0]     filtered_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [awd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CH_W     = awd_pkg::CH_W;
  localparam int SMP_W    = awd_pkg::SAMPLE_W;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = $clog2(WINDOW);
  localparam int SUM_MAX  = awd_pkg::SAMPLE_MAX * WINDOW + awd_pkg::SUM_SLACK;
  localparam int SUM_W    = $clog2(SUM_MAX + 1);
  localparam int SUMX_W   = SUM_W + 1;
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int RING_AW  = $clog2(RING_DEPTH);
  localparam int WORD_W   = 1 + POS_W + SUM_W + SMP_W;
  localparam int SHIFT    = SUM_W + POS_W;
  localparam int RECIP_W  = SUM_W + 2;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int Q_W      = PROD_W - SHIFT;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int CH_CAP   = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);

  localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [SUMX_W-1:0]  SUM_LIMIT = SUMX_W'(SUM_MAX);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
  localparam logic [CH_W:0]      CH_CAP_V  = (CH_W + 1)'(CH_CAP);
  localparam logic [Q_W-1:0]     AVG_MAX   = Q_W'(awd_pkg::SAMPLE_MAX);

  // Configuration registers.
  logic                     filter_enable;
  logic                     deadband_enable;
  logic [SMP_W-1:0]         deadband_threshold;
  logic [awd_pkg::CIU_W-1:0] channels_in_use;

  // Per-channel valid bits: an entry never written reads as zero.
  logic [CHANNELS-1:0] chan_vld;

  // Pipeline registers.
  logic                s1_valid;
  logic [CH_W-1:0]     s1_ch;
  logic [SMP_W-1:0]    s1_smp;

  logic                s2_valid;
  logic [CH_W-1:0]     s2_ch;
  logic [SMP_W-1:0]    s2_smp;
  logic [POS_W-1:0]    s2_pos;
  logic                s2_wrap;
  logic                s2_ring_ok;
  logic [SUM_W-1:0]    s2_sum;
  logic [SMP_W-1:0]    s2_held;

  logic                s3_valid;
  logic [CH_W-1:0]     s3_ch;
  logic [SMP_W-1:0]    s3_smp;
  logic [POS_W-1:0]    s3_pos;
  logic                s3_wrap;
  logic [SUM_W-1:0]    s3_sum;
  logic [SMP_W-1:0]    s3_held;

  logic                s4_valid;
  logic [CH_W-1:0]     s4_ch;
  logic [SMP_W-1:0]    s4_smp;
  logic [POS_W-1:0]    s4_pos;
  logic                s4_wrap;
  logic [SUM_W-1:0]    s4_sum;
  logic [PROD_W-1:0]   s4_prod;
  logic [SMP_W-1:0]    s4_held;

  // Copy of the last channel word written, which the RAM read of that edge missed.
  logic                s5_valid;
  logic [CH_W-1:0]     s5_ch;
  logic [POS_W-1:0]    s5_pos;
  logic                s5_wrap;
  logic [SUM_W-1:0]    s5_sum;
  logic [SMP_W-1:0]    s5_held;

  // Handshake and queue.
  logic                    in_fire;
  logic                    in_active;
  logic                    out_fire;
  awd_pkg::result_t        q_head;
  awd_pkg::result_t        q_push_data;
  awd_pkg::outq_status_t   q_status;
  logic [awd_pkg::OQ_CW:0] used;

  // Channel RAM and ring RAM ports.
  logic [CH_AW-1:0]   chan_raddr;
  logic [CH_AW-1:0]   chan_waddr;
  logic [WORD_W-1:0]  chan_rdata;
  logic [WORD_W-1:0]  chan_wdata;
  logic [RING_AW-1:0] ring_addr;
  logic               ring_we;
  logic [SMP_W-1:0]   ring_rdata;

  // Stage 1 resolved state.
  logic               mem_ok;
  logic               mem_wrap;
  logic [POS_W-1:0]   mem_pos;
  logic [SUM_W-1:0]   mem_sum;
  logic [SMP_W-1:0]   mem_held;
  logic [POS_W-1:0]   s1_pos;
  logic               s1_wrap;
  logic [SUM_W-1:0]   s1_sum;
  logic [SMP_W-1:0]   s1_held;
  logic               s1_at_last;
  logic [POS_W-1:0]   s1_pos_next;
  logic               s1_wrap_next;

  // Stage 2 sum update.
  logic [SMP_W-1:0]   ring_old;
  logic [SUMX_W-1:0]  sum_add;
  logic [SUMX_W-1:0]  sum_diff;
  logic               sum_ok;
  logic [SUM_W-1:0]   s2_sum_next;

  // Stage 4 average and deadband.
  logic [Q_W-1:0]     quo;
  logic [SMP_W-1:0]   avg;
  logic [SMP_W-1:0]   value;
  logic [SMP_W-1:0]   diff;
  logic               adopt;
  logic [SMP_W-1:0]   s4_held_next;
  logic [SMP_W-1:0]   s4_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable      <= 1'b0;
      deadband_enable    <= 1'b0;
      deadband_threshold <= awd_pkg::THRESHOLD_RESET;
      channels_in_use    <= awd_pkg::CIU_RESET;
    end else if (cfg_valid) begin
      unique case (awd_pkg::cfg_reg_t'(cfg_index))
        awd_pkg::REG_FILTER_ENABLE:      filter_enable      <= cfg_data[0];
        awd_pkg::REG_DEADBAND_ENABLE:    deadband_enable    <= cfg_data[0];
        awd_pkg::REG_DEADBAND_THRESHOLD: deadband_threshold <= cfg_data[SMP_W-1:0];
        awd_pkg::REG_CHANNELS_IN_USE:    channels_in_use    <= cfg_data[awd_pkg::CIU_W-1:0];
      endcase
    end
  end

  // Words in flight hold a queue slot in advance, so the pipeline never stalls.
  assign used = (awd_pkg::OQ_CW + 1)'(q_status.count) + (awd_pkg::OQ_CW + 1)'(s1_valid)
              + (awd_pkg::OQ_CW + 1)'(s2_valid) + (awd_pkg::OQ_CW + 1)'(s3_valid)
              + (awd_pkg::OQ_CW + 1)'(s4_valid);
  assign in_ready  = (used < (awd_pkg::OQ_CW + 1)'(awd_pkg::OUT_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign in_active = ({1'b0, channel} < channels_in_use) && ({1'b0, channel} < CH_CAP_V);

  assign chan_raddr = CH_AW'(channel);

  awd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (s4_valid),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .raddr (chan_raddr),
    .rdata (chan_rdata)
  );

  // Stage 1: resolve channel state from the RAM and from older words in flight.
  always_comb begin
    mem_ok   = chan_vld[CH_AW'(s1_ch)];
    mem_wrap = mem_ok ? chan_rdata[WORD_W-1] : 1'b0;
    mem_pos  = mem_ok ? chan_rdata[WORD_W-2 -: POS_W] : '0;
    mem_sum  = mem_ok ? chan_rdata[SMP_W +: SUM_W] : '0;
    mem_held = mem_ok ? chan_rdata[SMP_W-1:0] : '0;

    if (s2_valid && s2_ch == s1_ch) begin
      s1_pos  = s2_pos;
      s1_wrap = s2_wrap;
      s1_sum  = s2_sum_next;
    end else if (s3_valid && s3_ch == s1_ch) begin
      s1_pos  = s3_pos;
      s1_wrap = s3_wrap;
      s1_sum  = s3_sum;
    end else if (s4_valid && s4_ch == s1_ch) begin
      s1_pos  = s4_pos;
      s1_wrap = s4_wrap;
      s1_sum  = s4_sum;
    end else if (s5_valid && s5_ch == s1_ch) begin
      s1_pos  = s5_pos;
      s1_wrap = s5_wrap;
      s1_sum  = s5_sum;
    end else begin
      s1_pos  = mem_pos;
      s1_wrap = mem_wrap;
      s1_sum  = mem_sum;
    end

    // The held value is final only at stage 4; later updates are broadcast below.
    s1_held = (s5_valid && s5_ch == s1_ch) ? s5_held : mem_held;

    s1_at_last   = (s1_pos == POS_LAST);
    s1_pos_next  = s1_pos;
    s1_wrap_next = s1_wrap;
    if (filter_enable) begin
      s1_pos_next  = s1_at_last ? '0 : s1_pos + 1'b1;
      s1_wrap_next = s1_wrap || s1_at_last;
    end
  end

  // The ring entry is read and replaced in the same cycle.
  assign ring_addr = RING_AW'(s1_ch) * RING_AW'(WINDOW) + RING_AW'(s1_pos);
  assign ring_we   = s1_valid && filter_enable;

  awd_ram #(
    .WIDTH (SMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_addr),
    .wdata (s1_smp),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  // Stage 2: running sum update with the out-of-bounds clear.
  always_comb begin
    ring_old = s2_ring_ok ? ring_rdata : '0;
    sum_add  = {1'b0, s2_sum} + SUMX_W'(s2_smp);
    sum_diff = sum_add - SUMX_W'(ring_old);
    sum_ok   = (sum_add >= SUMX_W'(ring_old)) && (sum_diff <= SUM_LIMIT);
    if (filter_enable) begin
      s2_sum_next = sum_ok ? SUM_W'(sum_diff) : '0;
    end else begin
      s2_sum_next = s2_sum;
    end
  end

  // Stage 4: divide by the window through the reciprocal, then the deadband.
  always_comb begin
    quo   = s4_prod[PROD_W-1:SHIFT];
    avg   = (quo > AVG_MAX) ? SMP_W'(AVG_MAX) : SMP_W'(quo);
    value = filter_enable ? avg : s4_smp;
    diff  = (s4_held > value) ? s4_held - value : value - s4_held;
    adopt = (diff >= deadband_threshold);
    s4_held_next = s4_held;
    s4_out       = value;
    if (deadband_enable) begin
      if (adopt) begin
        s4_held_next = value;
      end else begin
        s4_out = s4_held;
      end
    end
  end

  assign chan_waddr = CH_AW'(s4_ch);
  assign chan_wdata = {s4_wrap, s4_pos, s4_sum, s4_held_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      chan_vld <= '0;
    end else begin
      s1_valid <= in_fire && in_active;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      if (s4_valid) begin
        chan_vld[CH_AW'(s4_ch)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ch  <= channel;
    s1_smp <= sample;

    s2_ch      <= s1_ch;
    s2_smp     <= s1_smp;
    s2_pos     <= s1_pos_next;
    s2_wrap    <= s1_wrap_next;
    s2_ring_ok <= s1_wrap;
    s2_sum     <= s1_sum;
    s2_held    <= (s4_valid && s4_ch == s1_ch) ? s4_held_next : s1_held;

    s3_ch   <= s2_ch;
    s3_smp  <= s2_smp;
    s3_pos  <= s2_pos;
    s3_wrap <= s2_wrap;
    s3_sum  <= s2_sum_next;
    s3_held <= (s4_valid && s4_ch == s2_ch) ? s4_held_next : s2_held;

    s4_ch   <= s3_ch;
    s4_smp  <= s3_smp;
    s4_pos  <= s3_pos;
    s4_wrap <= s3_wrap;
    s4_sum  <= s3_sum;
    s4_prod <= PROD_W'(s3_sum) * PROD_W'(RECIP_V);
    s4_held <= (s4_valid && s4_ch == s3_ch) ? s4_held_next : s3_held;

    s5_ch   <= s4_ch;
    s5_pos  <= s4_pos;
    s5_wrap <= s4_wrap;
    s5_sum  <= s4_sum;
    s5_held <= s4_held_next;
  end

  assign q_push_data.channel = s4_ch;
  assign q_push_data.value   = s4_out;

  awd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s4_valid),
    .push_data (q_push_data),
    .pop       (out_fire),
    .head      (q_head),
    .status    (q_status)
  );

  assign out_valid      = !q_status.empty;
  assign out_fire       = out_valid && out_ready;
  assign channel_out    = q_head.channel;
  assign filtered_value = q_head.value;

  `ASSERT_ALWAYS(a_slot_bound, clk, rst, used <= (awd_pkg::OQ_CW + 1)'(awd_pkg::OUT_DEPTH))
  `ASSERT_IMPLY(a_pos_range, clk, rst, s4_valid, s4_pos <= POS_LAST)
  `ASSERT_IMPLY(a_sum_range, clk, rst, s3_valid, {1'b0, s3_sum} <= SUM_LIMIT)

endmodule

### dv/testbench.sv
// Testbench for the window average deadband core: predicts every filtered word and checks it.
`timescale 1ns / 100ps
module testbench;
  import awd_pkg::*;

  localparam int NCH          = CHANNELS_DEFAULT;
  localparam int WIN          = WINDOW_DEFAULT;
  localparam int SETTLE       = 8;     // pipeline depth plus margin
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int LONG_HOLD    = 64;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CH_W-1:0]       channel = '0;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       channel_out;
  logic [SAMPLE_W-1:0]   filtered_value;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's configuration and per-channel filter state.
  logic                  filter_on;
  logic                  deadband_on;
  logic [SAMPLE_W-1:0]   threshold;
  logic [CIU_W-1:0]      channels_used;
  int                    window_sum [NCH];
  logic [SAMPLE_W-1:0]   window_hist [NCH][WIN];
  int                    window_pos [NCH];
  logic [SAMPLE_W-1:0]   held [NCH];

  result_t               pending_words [$];
  int                    mismatches = 0;
  int                    samples_taken = 0;
  int                    samples_ignored = 0;
  int                    words_checked = 0;
  int                    reg_writes = 0;
  int                    quiet_cycles = 0;

  bit                    feed_gaps = 1'b1;
  bit                    drain_gaps = 1'b1;
  int                    sink_hold_cycles = 0;

  adc_window_average_deadband_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel_out    (channel_out),
    .filtered_value (filtered_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Works out the word a sample produces and advances the shadow state.
  // Returns 0 when the channel is inactive and nothing comes out.
  function automatic bit predict_filtered(input logic [CH_W-1:0] ch,
                                          input logic [SAMPLE_W-1:0] smp,
                                          output logic [SAMPLE_W-1:0] val);
    int active;
    int total;
    int avg;
    int pos;
    int last;
    int diff;
    active = (channels_used > NCH) ? NCH : int'(channels_used);
    if (int'(ch) >= active) return 1'b0;
    val = smp;
    if (filter_on) begin
      pos = window_pos[ch];
      if (pos >= WIN) pos = 0;
      total = window_sum[ch] + int'(smp) - int'(window_hist[ch][pos]);
      if (total < 0 || total > SAMPLE_MAX * WIN + SUM_SLACK) total = 0;
      window_sum[ch] = total;
      window_hist[ch][pos] = smp;
      window_pos[ch] = (pos + 1) % WIN;
      avg = total / WIN;
      if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
      val = avg[SAMPLE_W-1:0];
    end
    if (deadband_on) begin
      last = int'(held[ch]);
      diff = (last > int'(val)) ? last - int'(val) : int'(val) - last;
      if (diff >= int'(threshold)) held[ch] = val;
      else val = held[ch];
    end
    return 1'b1;
  endfunction

  // Watches all three handshakes at the rising edge.
  always @(posedge clk) begin
    result_t exp_word;
    logic [SAMPLE_W-1:0] val;
    if (rst) begin
      filter_on = 1'b0;
      deadband_on = 1'b0;
      threshold = THRESHOLD_RESET;
      channels_used = CIU_RESET;
      for (int c = 0; c < NCH; c++) begin
        window_sum[c] = 0;
        window_pos[c] = 0;
        held[c] = '0;
        for (int w = 0; w < WIN; w++) window_hist[c][w] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: word with nothing expected: channel_out %0d filtered_value %0d",
                   $time, channel_out, filtered_value);
          mismatches++;
        end else begin
          exp_word = pending_words.pop_front();
          words_checked++;
          if (channel_out !== exp_word.channel) begin
            $display("%0t: channel_out expected %0d actual %0d",
                     $time, exp_word.channel, channel_out);
            mismatches++;
          end
          if (filtered_value !== exp_word.value) begin
            $display("%0t: filtered_value on channel %0d expected %0d actual %0d",
                     $time, exp_word.channel, exp_word.value, filtered_value);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        samples_taken++;
        if (predict_filtered(channel, sample, val)) begin
          exp_word.channel = channel;
          exp_word.value = val;
          pending_words.push_back(exp_word);
        end else begin
          samples_ignored++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_reg_t'(cfg_index))
          REG_FILTER_ENABLE:      filter_on = cfg_data[0];
          REG_DEADBAND_ENABLE:    deadband_on = cfg_data[0];
          REG_DEADBAND_THRESHOLD: threshold = cfg_data[SAMPLE_W-1:0];
          REG_CHANNELS_IN_USE:    channels_used = cfg_data[CIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // A hung handshake ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random back-pressure before each word, or one long hold on request.
  initial begin : result_sink
    int pause;
    forever begin
      @(negedge clk);
      pause = drain_gaps ? $urandom_range(0, 3) : 0;
      if (sink_hold_cycles > 0) begin
        pause = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one sample and returns at the edge that takes it. Valid is left high
  // so that a following call with no gap keeps the stream back to back.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    channel <= ch;
    sample <= smp;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the input, waits for every expected word, then lets the pipeline
  // settle in case the last samples were on inactive channels.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(input bit filt, input bit dband,
                                input logic [SAMPLE_W-1:0] thr, input logic [CIU_W-1:0] ciu);
    drain_results();
    write_register(REG_FILTER_ENABLE, CFG_DATA_W'(filt));
    write_register(REG_DEADBAND_ENABLE, CFG_DATA_W'(dband));
    write_register(REG_DEADBAND_THRESHOLD, thr);
    write_register(REG_CHANNELS_IN_USE, CFG_DATA_W'(ciu));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3, 4: v = int'(prev) + int'($urandom_range(0, 80)) - 40;
      default: v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // Reset settings pass samples through untouched; the patterns toggle every bit.
  task automatic test_passthrough();
    send_sample(4'd0, 12'h000);
    send_sample(4'd15, 12'hFFF);
    send_sample(4'd10, 12'hAAA);
    send_sample(4'd5, 12'h555);
  endtask

  task automatic test_channel_limit();
    write_settings(1'b0, 1'b0, 12'd16, 5'd0);
    send_sample(4'd0, 12'd100);
    write_settings(1'b0, 1'b0, 12'd16, 5'd5);
    send_sample(4'd4, 12'd200);
    send_sample(4'd5, 12'd300);
    // A count above the channel total behaves as all channels in use.
    write_settings(1'b0, 1'b0, 12'd16, 5'd31);
    send_sample(4'd15, 12'd400);
  endtask

  task automatic test_window_average();
    write_settings(1'b1, 1'b0, 12'd16, 5'd16);
    repeat (WIN) send_sample(4'd15, 12'hFFF);
    send_sample(4'd15, 12'h000);
    send_sample(4'd0, 12'd8);
  endtask

  task automatic test_deadband_hold();
    write_settings(1'b0, 1'b1, 12'd100, 5'd16);
    send_sample(4'd2, 12'd50);
    send_sample(4'd2, 12'd100);
    send_sample(4'd2, 12'd150);
    send_sample(4'd2, 12'hFFF);
    write_settings(1'b0, 1'b1, 12'd0, 5'd16);
    send_sample(4'd2, 12'hFFE);
    write_settings(1'b1, 1'b1, 12'hFFF, 5'd16);
    send_sample(4'd3, 12'hFFF);
    write_settings(1'b0, 1'b1, 12'hFFF, 5'd16);
    send_sample(4'd3, 12'hFFF);
    send_sample(4'd3, 12'h000);
  endtask

  // The sink stops for a long stretch while samples keep coming back to back,
  // so the result queue fills and the input stalls. Then the source waits it out.
  task automatic test_output_stall();
    write_settings(1'b1, 1'b1, 12'd20, 5'd16);
    feed_gaps = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    for (int i = 0; i < 30; i++)
      send_sample(4'($urandom_range(0, NCH - 1)), 12'($urandom_range(0, SAMPLE_MAX)));
    drain_results();
    feed_gaps = 1'b1;
  endtask

  task automatic test_random_phases(input int phases, input int words_per_phase);
    int active;
    int sent;
    int counted;
    int thr;
    int ciu;
    bit filt;
    bit dband;
    logic [CH_W-1:0] ch;
    logic [SAMPLE_W-1:0] recent [NCH];
    foreach (recent[i]) recent[i] = '0;
    for (int p = 0; p < phases; p++) begin
      filt = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      dband = ($urandom_range(0, 9) < 7);
      case (p)
        0: thr = 0;
        1: thr = SAMPLE_MAX;
        default:
          case ($urandom_range(0, 2))
            0: thr = $urandom_range(1, 64);
            1: thr = $urandom_range(65, 512);
            default: thr = $urandom_range(0, SAMPLE_MAX);
          endcase
      endcase
      if (p == 1) ciu = 1;
      else if (p == 2) ciu = 0;
      else
        case ($urandom_range(0, 5))
          0: ciu = $urandom_range(0, 31);
          1: ciu = $urandom_range(1, 15);
          default: ciu = NCH;
        endcase
      active = (ciu > NCH) ? NCH : ciu;
      drain_results();
      // Unused upper data bits carry junk; only the low bits of each field count.
      write_register(REG_FILTER_ENABLE,
                     (12'($urandom_range(0, 4095)) & 12'hFFE) | CFG_DATA_W'(filt));
      write_register(REG_DEADBAND_ENABLE,
                     (12'($urandom_range(0, 4095)) & 12'hFFE) | CFG_DATA_W'(dband));
      write_register(REG_DEADBAND_THRESHOLD, CFG_DATA_W'(thr));
      write_register(REG_CHANNELS_IN_USE,
                     {7'($urandom_range(0, 127)), 5'(ciu)});
      feed_gaps = (p % 4 != 1);
      drain_gaps = (p % 4 != 2);
      sent = 0;
      counted = 0;
      while (counted < words_per_phase && sent < words_per_phase + 40) begin
        if (active > 0 && $urandom_range(0, 9) != 0)
          ch = 4'($urandom_range(0, active - 1));
        else
          ch = 4'($urandom_range(0, NCH - 1));
        recent[ch] = pick_sample(recent[ch]);
        send_sample(ch, recent[ch]);
        sent++;
        if (int'(ch) < active) counted++;
      end
    end
    feed_gaps = 1'b1;
    drain_gaps = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_channel_limit();
    test_window_average();
    test_deadband_hold();
    test_output_stall();
    test_random_phases(12, 66);
    drain_results();
    $display("Run covered %0d samples (%0d on inactive channels), %0d words, %0d writes.",
             samples_taken, samples_ignored, words_checked, reg_writes);
    $display("Averaging, deadband hold, channel limits and a long output stall were exercised.");
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/awd_pkg.sv
rtl/awd_ram.sv
rtl/awd_outq.sv
rtl/adc_window_average_deadband_core.sv
dv/testbench.sv
